// ----- src/frml_pkg.sv -----
// Package for the frame rate meter and limiter.
// Holds field widths, fixed constants and the divider status type.
// No dependencies.
package frml_pkg;

  localparam int TS_W     = 32;  // timestamp width
  localparam int IVL_W    = 16;  // interval field width
  localparam int RATE_W   = 24;  // Q.8 rate field width
  localparam int FPS_W    = 10;  // max_fps / delay width
  localparam int SUM_W    = 24;  // running interval sum width
  localparam int DIV_W    = 24;  // serial divider operand width
  localparam int SUB_CNT_W = $clog2(TS_W);
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [DIV_W-1:0]  PERIOD_MS    = DIV_W'(1000);
  localparam logic [DIV_W-1:0]  RATE_SCALE   = DIV_W'(256000);
  localparam logic [RATE_W-1:0] DEFAULT_RATE = RATE_W'(60 * 256);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/frame_rate_meter_limiter.sv -----
// Frame rate meter and limiter, top level.
// Depends on frml_pkg, frml_serial_sub, frml_serial_div and frml_ring.
// Usage:
//   One input item per frame end on in_* (start and end timestamps in ms).
//   One result item per input on out_*: interval since the previous frame
//   end, moving-average rate over the last SAMPLES intervals (Q.8), the
//   reported rate and the delay that meets the max_fps cap. The user must
//   write max_fps on cfg_* when idle; unenforced, as cfg_ready is high.
// Timing:
//   An item goes from acceptance to out_tvalid through bit-serial timestamp
//   subtraction (the cap period divides meanwhile), the ring and sum
//   update, bit-serial division for the rate and its done flag, then
//   the output register load. The 32-bit serial subtractors and the shared
//   serial divider set the length of this sequence. One item is in work at
//   a time; the next is taken once the previous result is in the output
//   register, even if the receiver has not yet taken it.
// Reset and stall:
//   rst_n (synchronous) clears the sum, fill count, ring slot, first-frame
//   flag and max_fps. While out_tready is low the finished result holds and
//   the next item waits before its own output load.
module frame_rate_meter_limiter #(
  parameter int SAMPLES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [31:0] start_time_ms, [63:32] end_time_ms
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // out_tdata: [15:0] frame_interval_ms, [39:16] measured_rate_q8,
  //            [63:40] reported_rate_q8, [73:64] delay_ms, [79:74] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);
  import frml_pkg::*;

  localparam int SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int FILL_W = $clog2(SAMPLES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUB  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]           state_r;
  logic [SUB_CNT_W-1:0] cnt_r;
  logic [FPS_W-1:0]     max_fps_r;
  logic [SUM_W-1:0]     sum_r;
  logic [FILL_W-1:0]    fill_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [TS_W-1:0]      prev_end_r;
  logic                 seen_r;
  logic                 first_r;
  logic                 sum_zero_r;
  logic [IVL_W-1:0]     ivl_r;
  logic [FPS_W-1:0]     delay_r;
  logic [RATE_W-1:0]    rate_r;
  logic                 out_valid_r;
  logic [79:0]          out_data_r;

  logic                 in_acc;
  logic [TS_W-1:0]      ts_start, ts_end;
  logic [TS_W-1:0]      ivl_diff, busy_diff;
  logic [IVL_W-1:0]     hist_rd;
  logic [IVL_W-1:0]     ivl_nxt;
  logic                 full;
  logic [SUM_W-1:0]     sum_nxt;
  logic [FILL_W-1:0]    fill_nxt;
  logic [SLOT_W-1:0]    slot_nxt;
  logic [FPS_W-1:0]     period;
  logic [FPS_W-1:0]     delay_nxt;
  logic                 div_start;
  logic [DIV_W-1:0]     div_num, div_den, div_quot;
  div_stat_t            div_stat;
  logic [RATE_W-1:0]    reported;
  logic                 out_free;

  assign ts_start  = in_tdata[TS_W-1:0];
  assign ts_end    = in_tdata[2*TS_W-1:TS_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  frml_serial_sub u_sub_ivl (
    .clk   (clk),
    .load  (in_acc),
    .shift (state_r == ST_SUB),
    .a     (ts_end),
    .b     (prev_end_r),
    .diff  (ivl_diff)
  );

  frml_serial_sub u_sub_busy (
    .clk   (clk),
    .load  (in_acc),
    .shift (state_r == ST_SUB),
    .a     (ts_end),
    .b     (ts_start),
    .diff  (busy_diff)
  );

  frml_ring #(
    .SAMPLES (SAMPLES),
    .SLOT_W  (SLOT_W)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == ST_UPD),
    .waddr (slot_r),
    .wdata (ivl_nxt),
    .re    (in_acc),
    .raddr (slot_r),
    .rdata (hist_rd)
  );

  // The divider first works out the cap period, then the rate.
  always_comb begin
    div_start = in_acc || (state_r == ST_UPD);
    if (state_r == ST_UPD) begin
      div_num = DIV_W'(fill_nxt) * RATE_SCALE;
      div_den = DIV_W'(sum_nxt);
    end else begin
      div_num = PERIOD_MS;
      div_den = DIV_W'(max_fps_r);
    end
  end

  frml_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  always_comb begin
    if (first_r) begin
      ivl_nxt = '0;
    end else if (ivl_diff[TS_W-1:IVL_W] != '0) begin
      ivl_nxt = '1;
    end else begin
      ivl_nxt = ivl_diff[IVL_W-1:0];
    end
    full = (fill_r >= FILL_W'(SAMPLES));
    if (full) begin
      sum_nxt  = sum_r - SUM_W'(hist_rd) + SUM_W'(ivl_nxt);
      fill_nxt = FILL_W'(SAMPLES);
    end else begin
      sum_nxt  = sum_r + SUM_W'(ivl_nxt);
      fill_nxt = fill_r + 1'b1;
    end
    if (slot_r == SLOT_W'(SAMPLES - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + 1'b1;
    end
    period = div_quot[FPS_W-1:0];
    if (max_fps_r != '0 && busy_diff[TS_W-1:FPS_W] == '0 &&
        period > busy_diff[FPS_W-1:0]) begin
      delay_nxt = period - busy_diff[FPS_W-1:0];
    end else begin
      delay_nxt = '0;
    end
    if (max_fps_r != '0) begin
      reported = RATE_W'({max_fps_r, 8'h00});
    end else begin
      reported = rate_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      max_fps_r   <= '0;
      sum_r       <= '0;
      fill_r      <= '0;
      slot_r      <= '0;
      prev_end_r  <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_fps_r <= cfg_data;
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            prev_end_r <= ts_end;
            seen_r     <= 1'b1;
            cnt_r      <= '0;
            state_r    <= ST_SUB;
          end
        end
        ST_SUB: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == SUB_CNT_W'(TS_W - 1)) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          sum_r   <= sum_nxt;
          fill_r  <= fill_nxt;
          slot_r  <= slot_nxt;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      first_r <= !seen_r;
    end
    if (state_r == ST_UPD) begin
      ivl_r      <= ivl_nxt;
      delay_r    <= delay_nxt;
      sum_zero_r <= (sum_nxt == '0);
    end
    if (state_r == ST_DIV && div_stat.done) begin
      rate_r <= sum_zero_r ? DEFAULT_RATE : div_quot[RATE_W-1:0];
    end
    if (state_r == ST_OUT && out_free) begin
      out_data_r <= {6'b0, delay_r, reported, rate_r, ivl_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The period division must be over before the divider is reused.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> !div_stat.busy)
    else $error("divider still busy at ring update");

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(SAMPLES))
    else $error("fill count beyond ring depth");

  a_acc_sub: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SUB) && (cnt_r == '0))
    else $error("accepted item did not start subtraction");

  a_rate_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && div_stat.done |=> (state_r == ST_OUT))
    else $error("rate division result lost");

endmodule

// ----- src/frml_serial_sub.sv -----
// Bit-serial subtractor: a minus b, LSB up, one bit per shift cycle.
// Uses frml_pkg for the timestamp width.
module frml_serial_sub (
  input  logic                     clk,
  input  logic                     load,
  input  logic                     shift,
  input  logic [frml_pkg::TS_W-1:0] a,
  input  logic [frml_pkg::TS_W-1:0] b,
  output logic [frml_pkg::TS_W-1:0] diff
);
  import frml_pkg::*;

  logic [TS_W-1:0] a_r, b_r, diff_r;
  logic            borrow_r;
  logic            d_bit, borrow_nxt;

  assign d_bit      = a_r[0] ^ b_r[0] ^ borrow_r;
  assign borrow_nxt = (~a_r[0] & b_r[0]) | (~(a_r[0] ^ b_r[0]) & borrow_r);

  always_ff @(posedge clk) begin
    if (load) begin
      a_r      <= a;
      b_r      <= b;
      borrow_r <= 1'b0;
    end else if (shift) begin
      a_r      <= {1'b0, a_r[TS_W-1:1]};
      b_r      <= {1'b0, b_r[TS_W-1:1]};
      borrow_r <= borrow_nxt;
      diff_r   <= {d_bit, diff_r[TS_W-1:1]};
    end
  end

  assign diff = diff_r;

endmodule

// ----- src/frml_serial_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
// Uses frml_pkg for the operand width and the status struct.
module frml_serial_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [frml_pkg::DIV_W-1:0] num,
  input  logic [frml_pkg::DIV_W-1:0] den,
  output logic [frml_pkg::DIV_W-1:0] quot,
  output frml_pkg::div_stat_t       stat
);
  import frml_pkg::*;

  logic [DIV_W-1:0]     num_r, den_r, rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r, done_r;
  logic [DIV_W:0]       trial;
  logic                 q_bit;
  logic [DIV_W-1:0]     rem_nxt;

  always_comb begin
    trial = {rem_r, num_r[DIV_W-1]};
    q_bit = (trial >= {1'b0, den_r});
    if (q_bit) begin
      rem_nxt = DIV_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The dividend register fills with quotient bits as it shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[DIV_W-2:0], q_bit};
    end
  end

  assign quot      = num_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

// ----- src/frml_ring.sv -----
// Interval history ring: one write port, one registered read port.
// Uses frml_pkg for the interval width.
module frml_ring #(
  parameter int SAMPLES = 10,
  parameter int SLOT_W  = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [SLOT_W-1:0]          waddr,
  input  logic [frml_pkg::IVL_W-1:0] wdata,
  input  logic                       re,
  input  logic [SLOT_W-1:0]          raddr,
  output logic [frml_pkg::IVL_W-1:0] rdata
);
  import frml_pkg::*;

  logic [IVL_W-1:0] mem [SAMPLES];
  logic [IVL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- verif/frame_rate_meter_limiter_tb.sv -----
// Testbench for frame_rate_meter_limiter: streams frame timestamps and checks every result
// against an in-bench model of the interval ring, the moving-average rate and the rate cap.
// Depends on frml_pkg and the frame_rate_meter_limiter RTL.
module frame_rate_meter_limiter_tb;
  import frml_pkg::*;

  localparam int RING_DEPTH = 10;
  localparam int LATENCY    = 59;
  localparam int IDLE_PCT   = 21;

  typedef struct packed {
    logic [IVL_W-1:0]  interval;
    logic [RATE_W-1:0] measured;
    logic [RATE_W-1:0] reported;
    logic [FPS_W-1:0]  delay;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;    // [31:0] start_time_ms, [63:32] end_time_ms
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;        // [15:0] interval, [39:16] measured, [63:40] reported,
                                 // [73:64] delay_ms
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_data = '0;

  // Model of the block's state.
  logic [IVL_W-1:0] ring [RING_DEPTH];
  logic [SUM_W-1:0] ring_sum = '0;
  int unsigned      ring_fill = 0;
  int unsigned      ring_slot = 0;
  logic [TS_W-1:0]  last_end = '0;
  bit               have_frame = 1'b0;
  logic [FPS_W-1:0] fps_cap = '0;

  frame_result_t pending_results[$];
  bit            steady = 1'b0;
  int            stall_left = 0;
  int            mismatches = 0;
  int            frames_sent = 0;
  int            results_checked = 0;
  int            cfg_writes = 0;

  frame_rate_meter_limiter #(.SAMPLES(RING_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic frame_result_t predict_frame(input logic [TS_W-1:0] t_start,
                                                  input logic [TS_W-1:0] t_end);
    frame_result_t r;
    logic [TS_W-1:0] diff;
    logic [TS_W-1:0] busy;
    logic [63:0]     quot;
    int unsigned     period;
    diff = t_end - last_end;
    r.interval = '0;
    if (have_frame) r.interval = (diff > 32'hFFFF) ? 16'hFFFF : diff[15:0];
    have_frame = 1'b1;
    last_end = t_end;
    // Once the ring is full, the oldest interval drops out of the sum.
    if (ring_fill >= RING_DEPTH) ring_sum = ring_sum - ring[ring_slot];
    else ring_fill++;
    ring[ring_slot] = r.interval;
    ring_sum = ring_sum + r.interval;
    ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
    if (ring_sum == 0) begin
      r.measured = DEFAULT_RATE;
    end else begin
      quot = (64'(ring_fill) * 64'd256000) / 64'(ring_sum);
      r.measured = (quot > 64'hFFFFFF) ? 24'hFFFFFF : quot[23:0];
    end
    r.delay = '0;
    r.reported = r.measured;
    if (fps_cap != 0) begin
      period = 1000 / fps_cap;
      // A start after the end wraps to a huge busy time and so gives no delay.
      busy = t_end - t_start;
      if (period > busy) r.delay = FPS_W'(period - busy);
      r.reported = RATE_W'(fps_cap) << 8;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_val);
    $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want_val);
    mismatches++;
  endtask

  task automatic send_frame(input logic [TS_W-1:0] t_start, input logic [TS_W-1:0] t_end);
    int gap;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(72, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {t_end, t_start};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_frame(t_start, t_end));
    frames_sent++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_max_fps(input logic [FPS_W-1:0] fps);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data <= fps;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fps_cap = fps;
    cfg_writes++;
  endtask

  // Receiver: random single-cycle stalls plus an occasional long one.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else if ($urandom_range(99) < IDLE_PCT) begin
      out_tready <= 1'b0;
      if ($urandom_range(19) == 0) stall_left <= $urandom_range(80, 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no frame outstanding, interval", out_tdata[15:0], 0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[15:0] != want.interval)
          report_mismatch("frame_interval_ms", out_tdata[15:0], want.interval);
        if (out_tdata[39:16] != want.measured)
          report_mismatch("measured_rate_q8", out_tdata[39:16], want.measured);
        if (out_tdata[63:40] != want.reported)
          report_mismatch("reported_rate_q8", out_tdata[63:40], want.reported);
        if (out_tdata[73:64] != want.delay)
          report_mismatch("delay_ms", out_tdata[73:64], want.delay);
        results_checked++;
      end
    end
  end

  // Uncapped: first frame, zero sum, long gap, timestamp wrap and ring eviction.
  task automatic test_first_frames();
    send_frame(32'd990, 32'd1000);
    send_frame(32'd1000, 32'd1000);
    send_frame(32'd1004, 32'd1016);
    send_frame(32'h0000_0000, 32'hFFFF_FFFF);
    send_frame(32'hFFFF_FFFF, 32'h0000_000F);
    repeat (7) send_frame(last_end + 32'd3, last_end + 32'd33);
  endtask

  task automatic test_rate_cap();
    write_max_fps(FPS_W'(60));
    send_frame(last_end + 32'd11, last_end + 32'd16);
    send_frame(last_end, last_end + 32'd16);
    send_frame(last_end + 32'd40, last_end + 32'd20);
    write_max_fps(FPS_W'(1));
    send_frame(last_end + 32'd1000, last_end + 32'd1000);
    write_max_fps(FPS_W'(1000));
    send_frame(last_end + 32'd5, last_end + 32'd5);
    write_max_fps(FPS_W'(1023));
    send_frame(last_end + 32'd2, last_end + 32'd4);
    write_max_fps(FPS_W'(1001));
    send_frame(last_end + 32'd1, last_end + 32'd7);
    write_max_fps(FPS_W'(0));
    send_frame(last_end + 32'd3, last_end + 32'd9);
  endtask

  // Back-to-back frames with neither side idling.
  task automatic test_steady_stream();
    logic [TS_W-1:0] t_end;
    write_max_fps(FPS_W'(144));
    steady = 1'b1;
    repeat (150) begin
      t_end = last_end + $urandom_range(12, 4);
      send_frame(t_end - $urandom_range(10, 0), t_end);
    end
    wait_for_results();
    steady = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned     roll;
    int unsigned     period;
    logic [TS_W-1:0] t_end;
    logic [TS_W-1:0] t_start;
    logic [FPS_W-1:0] fps;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: fps = FPS_W'(0);
        1: fps = FPS_W'(1000);
        2: fps = FPS_W'(1023);
        3: fps = FPS_W'(1);
        default: fps = ($urandom_range(3) == 0) ? FPS_W'(0) : FPS_W'($urandom_range(1023, 1));
      endcase
      write_max_fps(fps);
      period = (fps_cap != 0) ? 1000 / fps_cap : 40;
      repeat (90) begin
        roll = $urandom_range(99);
        if (roll < 75) begin
          // Plausible frame: short interval, busy time around the cap period.
          if ($urandom_range(3) == 0) t_end = last_end + $urandom_range(3, 0);
          else t_end = last_end + $urandom_range(60, 1);
          t_start = t_end - $urandom_range(period + 5, 0);
        end else if (roll < 85) begin
          t_end = last_end + $urandom_range(200000, 60000);
          t_start = t_end - $urandom_range(30, 0);
        end else begin
          t_end = $urandom;
          t_start = $urandom;
        end
        send_frame(t_start, t_end);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_first_frames();
    test_rate_cap();
    test_steady_stream();
    test_random_frames();
    wait_for_results();
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d frames, checked %0d results, wrote max_fps %0d times.",
             frames_sent, results_checked, cfg_writes);
    $display("Cases: first frame, zero sum, long gaps, wraps, caps 0/1/60/1000/1001/1023.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
